// File: hdl/tks_pkg.sv
package tks_pkg;

  localparam int LenA = 93;
  localparam int LenB = 84;
  localparam int LenC = 111;
  localparam int KeyIvBits = 80;
  localparam int WarmSteps = 4 * 288;
  localparam int ByteBits = 8;
  localparam int CntW = $clog2(WarmSteps);
  localparam int CfgW = 64;
  localparam int IdxW = 2;

  typedef enum logic [IdxW-1:0] {
    REG_KEY_LOW  = 2'd0,
    REG_KEY_HIGH = 2'd1,
    REG_IV_LOW   = 2'd2,
    REG_IV_HIGH  = 2'd3
  } reg_index_t;

  // Operation field of an input item.
  typedef enum logic {
    OP_INIT = 1'b0,
    OP_DATA = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WARM,
    ST_DATA,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [LenA-1:0] a;
    logic [LenB-1:0] b;
    logic [LenC-1:0] c;
  } cipher_state_t;

  // One cipher step: returns the keystream bit and the advanced state.
  function automatic logic step(input cipher_state_t s, output cipher_state_t s_next);
    logic t1;
    logic t2;
    logic t3;
    logic z;
    t1 = s.a[65] ^ s.a[92];
    t2 = s.b[68] ^ s.b[83];
    t3 = s.c[65] ^ s.c[110];
    z = t1 ^ t2 ^ t3;
    t1 = t1 ^ (s.a[90] & s.a[91]) ^ s.b[77];
    t2 = t2 ^ (s.b[81] & s.b[82]) ^ s.c[86];
    t3 = t3 ^ (s.c[108] & s.c[109]) ^ s.a[68];
    s_next.a = {s.a[LenA-2:0], t3};
    s_next.b = {s.b[LenB-2:0], t1};
    s_next.c = {s.c[LenC-2:0], t2};
    return z;
  endfunction

endpackage

// File: hdl/tks_ifs.sv
interface tks_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink (input valid, input operation, input data_byte, output ready);
endinterface

interface tks_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_byte;

  modport source (output valid, output result_byte, input ready);
  modport sink (input valid, input result_byte, output ready);
endinterface

// File: hdl/trivium_keystream_xor.sv
// Operation: an initialize item keeps the block busy for the warm-up steps and gives no
// result; a data item runs 8 cipher steps and loads the output register once it is free.
// Throughput: one cipher step per cycle, while warming up or stepping data, through a
// single shared step unit; a new item is taken only once the last one is through. Reset
// (rst, synchronous, active high) clears the cipher state, key, IV and all handshakes.
module trivium_keystream_xor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          write_enable,
  input  logic [tks_pkg::IdxW-1:0]      reg_index,
  input  logic [tks_pkg::CfgW-1:0]      write_data,
  tks_in_if.sink                        req,
  tks_out_if.source                     rsp
);

  // Key and IV configuration registers. They take effect at the next initialize.
  logic [63:0] key_low;
  logic [15:0] key_high;
  logic [63:0] iv_low;
  logic [15:0] iv_high;

  // The three cipher shift registers, held as one record.
  tks_pkg::cipher_state_t cs;
  tks_pkg::cipher_state_t cs_next;
  tks_pkg::cipher_state_t cs_step;
  logic                   z;

  tks_pkg::state_t           state;
  tks_pkg::state_t           state_next;
  logic [tks_pkg::CntW-1:0]  cnt;
  logic [tks_pkg::CntW-1:0]  cnt_next;

  // Keystream bits collected for the current byte, first bit ends in bit 7.
  logic [7:0] ks;
  logic [7:0] ks_next;
  logic [7:0] data;
  logic [7:0] result;
  logic       out_valid;
  logic       out_valid_next;
  logic       load_result;
  logic       accept;

  // Configuration writes are plain register updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
      iv_low   <= '0;
      iv_high  <= '0;
    end else if (write_enable) begin
      case (tks_pkg::reg_index_t'(reg_index))
        tks_pkg::REG_KEY_LOW:  key_low  <= write_data;
        tks_pkg::REG_KEY_HIGH: key_high <= write_data[15:0];
        tks_pkg::REG_IV_LOW:   iv_low   <= write_data;
        tks_pkg::REG_IV_HIGH:  iv_high  <= write_data[15:0];
        default: ;
      endcase
    end
  end

  // The single shared step unit: one keystream bit per cycle.
  always_comb begin
    z = tks_pkg::step(cs, cs_step);
  end

  assign req.ready = (state == tks_pkg::ST_IDLE);
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tks_pkg::ST_IDLE;
      cnt       <= '0;
      cs        <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      cs        <= cs_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    ks <= ks_next;
    if (accept) begin
      data <= req.data_byte;
    end
    if (load_result) begin
      result <= data ^ ks;
    end
  end

  // Sequencer: an initialize loads key and IV and then runs the warm-up steps; a data
  // item runs eight steps and then waits until the output register is free.
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cs_next        = cs;
    ks_next        = ks;
    load_result    = 1'b0;
    out_valid_next = out_valid && !rsp.ready;
    case (state)
      tks_pkg::ST_IDLE: begin
        if (accept) begin
          cnt_next = '0;
          if (req.operation == tks_pkg::OP_DATA) begin
            state_next = tks_pkg::ST_DATA;
          end else begin
            cs_next.a = {{(tks_pkg::LenA - tks_pkg::KeyIvBits){1'b0}}, key_high, key_low};
            cs_next.b = {{(tks_pkg::LenB - tks_pkg::KeyIvBits){1'b0}}, iv_high, iv_low};
            cs_next.c = {3'b111, {(tks_pkg::LenC - 3){1'b0}}};
            state_next = tks_pkg::ST_WARM;
          end
        end
      end
      tks_pkg::ST_WARM: begin
        cs_next  = cs_step;
        cnt_next = cnt + 1'b1;
        if (cnt == tks_pkg::CntW'(tks_pkg::WarmSteps - 1)) begin
          state_next = tks_pkg::ST_IDLE;
        end
      end
      tks_pkg::ST_DATA: begin
        cs_next  = cs_step;
        ks_next  = {ks[6:0], z};
        cnt_next = cnt + 1'b1;
        if (cnt == tks_pkg::CntW'(tks_pkg::ByteBits - 1)) begin
          state_next = tks_pkg::ST_FIN;
        end
      end
      tks_pkg::ST_FIN: begin
        if (!out_valid || rsp.ready) begin
          load_result    = 1'b1;
          out_valid_next = 1'b1;
          state_next     = tks_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tks_pkg::ST_IDLE;
      end
    endcase
  end

  assign rsp.valid       = out_valid;
  assign rsp.result_byte = result;

endmodule
